### rtl/core/tts_pkg.sv
// Shared types, codes and byte-class functions of the text token scanner.
// Used by the lexer step, the result queue, the top level and the checker.
`default_nettype none

package tts_pkg;

  // Token type codes as they leave on the result stream
  localparam logic [2:0] TOK_END     = 3'd0;
  localparam logic [2:0] TOK_INT     = 3'd1;
  localparam logic [2:0] TOK_DBL     = 3'd2;
  localparam logic [2:0] TOK_IDENT   = 3'd3;
  localparam logic [2:0] TOK_STR     = 3'd4;
  localparam logic [2:0] TOK_PUNCT   = 3'd5;
  localparam logic [2:0] TOK_INVALID = 3'd6;

  // Scan mode codes
  localparam logic [2:0] MODE_IDLE   = 3'd0;
  localparam logic [2:0] MODE_SIGN   = 3'd1;
  localparam logic [2:0] MODE_MANT   = 3'd2;
  localparam logic [2:0] MODE_EXP    = 3'd3;
  localparam logic [2:0] MODE_EXPD   = 3'd4;
  localparam logic [2:0] MODE_IDENT  = 3'd5;
  localparam logic [2:0] MODE_STRING = 3'd6;

  // Register indexes on the configuration port
  localparam logic [1:0] REG_COMMENT_CHARS = 2'd0;
  localparam logic [1:0] REG_IDENT_EXTRA   = 2'd1;
  localparam logic [1:0] REG_WANT_NEWLINE  = 2'd2;

  // Byte constants
  localparam logic [7:0] CH_LOW_E  = 8'h65;
  localparam logic [7:0] CH_UP_E   = 8'h45;
  localparam logic [7:0] CH_LOW_F  = 8'h66;
  localparam logic [7:0] CH_UP_F   = 8'h46;
  localparam logic [7:0] CH_DOT    = 8'h2E;
  localparam logic [7:0] CH_PLUS   = 8'h2B;
  localparam logic [7:0] CH_MINUS  = 8'h2D;
  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CH_LF     = 8'h0A;
  localparam logic [7:0] CH_DQUOTE = 8'h22;
  localparam logic [7:0] CH_SQUOTE = 8'h27;
  localparam logic [7:0] CH_UNDER  = 8'h5F;

  localparam int unsigned LINE_W     = 32;
  localparam int unsigned FIELD_POS_W = 32;
  localparam int unsigned OUT_TDATA_W = 104;
  localparam int unsigned FIFO_DEPTH  = 4;

  typedef struct packed {
    logic [2:0] mode;
    logic       seen_dot;
    logic       is_floating;
    logic [7:0] quote_byte;
    logic       in_comment;
    logic       pending_cr;
  } scan_ctl_t;

  typedef struct packed {
    logic [2:0]             tok_type;
    logic [FIELD_POS_W-1:0] tok_start;
    logic [FIELD_POS_W-1:0] tok_stop;
    logic [LINE_W-1:0]      line;
    logic                   last;
  } res_t;

  function automatic logic is_digit(input logic [7:0] ch);
    return (ch >= 8'h30) && (ch <= 8'h39);
  endfunction

  function automatic logic is_space(input logic [7:0] ch);
    return ((ch >= 8'd9) && (ch <= 8'd13)) || (ch == 8'd32);
  endfunction

  function automatic logic is_punct(input logic [7:0] ch);
    return ((ch >= 8'd33) && (ch <= 8'd47)) || ((ch >= 8'd58) && (ch <= 8'd64)) ||
           ((ch >= 8'd91) && (ch <= 8'd96)) || ((ch >= 8'd123) && (ch <= 8'd126));
  endfunction

  function automatic logic is_alpha(input logic [7:0] ch);
    return ((ch >= 8'h41) && (ch <= 8'h5A)) || ((ch >= 8'h61) && (ch <= 8'h7A));
  endfunction

  // Match against four byte lanes; a zero byte never matches
  function automatic logic in_lanes(input logic [31:0] word, input logic [7:0] ch);
    logic hit;
    hit = 1'b0;
    for (int i = 0; i < 4; i++) begin
      if (word[8*i +: 8] == ch) hit = 1'b1;
    end
    return hit && (ch != 8'h00);
  endfunction

  function automatic logic ident_begin(input logic [31:0] extra, input logic [7:0] ch);
    return is_alpha(ch) || (ch == CH_UNDER) || in_lanes(extra, ch);
  endfunction

  function automatic res_t mk_res(input logic [2:0] ty, input logic [FIELD_POS_W-1:0] s,
                                  input logic [FIELD_POS_W-1:0] e,
                                  input logic [LINE_W-1:0] ln);
    res_t r;
    r.tok_type  = ty;
    r.tok_start = s;
    r.tok_stop  = e;
    r.line      = ln;
    r.last      = 1'b0;
    return r;
  endfunction

endpackage

`default_nettype wire

### rtl/core/tts_lexer.sv
// One scan step of the tokenizer: comment filter, token state update and
// up to two result tokens per byte. Pure logic; depends on tts_pkg.
`default_nettype none

module tts_lexer import tts_pkg::*; #(
  parameter int unsigned PosW = 32
) (
  input  wire logic [31:0]       comment_chars_i,
  input  wire logic [31:0]       ident_extra_i,
  input  wire logic              want_newline_i,
  input  wire logic              action_i,
  input  wire logic [7:0]        byte_i,
  input  wire logic [PosW-1:0]   pos_i,
  input  scan_ctl_t              ctl_i,
  input  wire logic [PosW-1:0]   start_pos_i,
  input  wire logic [PosW-1:0]   last_pos_i,
  input  wire logic [LINE_W-1:0] line_i,
  output scan_ctl_t              ctl_o,
  output logic [PosW-1:0]        start_pos_o,
  output logic [PosW-1:0]        last_pos_o,
  output logic [LINE_W-1:0]      line_o,
  output res_t                   res0_o,
  output res_t                   res1_o,
  output logic [1:0]             res_cnt_o
);

  logic                   is_end;
  logic [7:0]             ch;
  logic [FIELD_POS_W-1:0] p_w, start_w, last_w;
  logic                   run, finish, go_idle;
  logic                   e1_v, e2_v;
  res_t                   e1, e2;

  assign is_end  = action_i | (byte_i == 8'h00);
  assign ch      = is_end ? 8'h00 : byte_i;
  assign p_w     = FIELD_POS_W'(pos_i);
  assign start_w = FIELD_POS_W'(start_pos_i);
  assign last_w  = FIELD_POS_W'(last_pos_i);

  always_comb begin
    ctl_o       = ctl_i;
    start_pos_o = start_pos_i;
    last_pos_o  = last_pos_i;
    line_o      = line_i;
    run         = 1'b0;
    finish      = 1'b0;
    go_idle     = 1'b0;
    e1_v        = 1'b0;
    e2_v        = 1'b0;
    e1          = '0;
    e2          = '0;

    // Comment filter
    if (is_end) begin
      ctl_o.in_comment = 1'b0;
      run = 1'b1;
    end else if (ctl_i.in_comment) begin
      if ((ch == CH_CR) || (ch == CH_LF)) begin
        ctl_o.in_comment = 1'b0;
        run = 1'b1;
      end
    end else if (in_lanes(comment_chars_i, ch)) begin
      ctl_o.in_comment = 1'b1;
    end else begin
      run = 1'b1;
    end

    // Open token modes
    if (run) begin
      case (ctl_i.mode)
        MODE_SIGN: begin
          if (!is_end && ((ch == CH_DOT) || is_digit(ch))) begin
            ctl_o.seen_dot    = (ch == CH_DOT);
            ctl_o.is_floating = (ch == CH_DOT);
            last_pos_o        = pos_i;
            ctl_o.mode        = MODE_MANT;
          end else begin
            e1_v    = 1'b1;
            e1      = mk_res(TOK_PUNCT, start_w, start_w, line_i);
            go_idle = 1'b1;
          end
        end
        MODE_MANT: begin
          if (is_end) begin
            finish = 1'b1;
          end else if (ch == CH_DOT) begin
            if (ctl_i.seen_dot) begin
              e1_v       = 1'b1;
              e1         = mk_res(TOK_INVALID, start_w, p_w, line_i);
              ctl_o.mode = MODE_IDLE;
            end else begin
              ctl_o.seen_dot    = 1'b1;
              ctl_o.is_floating = 1'b1;
              last_pos_o        = pos_i;
            end
          end else if (is_digit(ch)) begin
            last_pos_o = pos_i;
          end else if ((ch == CH_LOW_E) || (ch == CH_UP_E)) begin
            ctl_o.is_floating = 1'b1;
            last_pos_o        = pos_i;
            ctl_o.mode        = MODE_EXP;
          end else begin
            finish = 1'b1;
          end
        end
        MODE_EXP: begin
          if (!is_end && ((ch == CH_PLUS) || (ch == CH_MINUS) || is_digit(ch))) begin
            last_pos_o = pos_i;
            ctl_o.mode = MODE_EXPD;
          end else begin
            finish = 1'b1;
          end
        end
        MODE_EXPD: begin
          if (!is_end && is_digit(ch)) begin
            last_pos_o = pos_i;
          end else begin
            finish = 1'b1;
          end
        end
        MODE_IDENT: begin
          if (!is_end && (ident_begin(ident_extra_i, ch) || is_digit(ch))) begin
            last_pos_o = pos_i;
          end else begin
            e1_v    = 1'b1;
            e1      = mk_res(TOK_IDENT, start_w, last_w, line_i);
            go_idle = 1'b1;
          end
        end
        MODE_STRING: begin
          if (is_end) begin
            e1_v    = 1'b1;
            e1      = mk_res(TOK_INVALID, start_w, last_w, line_i);
            go_idle = 1'b1;
          end else if (ch == ctl_i.quote_byte) begin
            e1_v       = 1'b1;
            e1         = mk_res(TOK_STR, start_w, p_w, line_i);
            ctl_o.mode = MODE_IDLE;
          end else begin
            last_pos_o = pos_i;
          end
        end
        default: begin
          go_idle = 1'b1;
        end
      endcase
    end

    // Close a number: f suffix, clean delimiter or trailing junk
    if (finish) begin
      ctl_o.mode = MODE_IDLE;
      e1_v       = 1'b1;
      if (!is_end && ((ch == CH_LOW_F) || (ch == CH_UP_F))) begin
        e1 = mk_res(TOK_DBL, start_w, p_w, line_i);
      end else if (is_end || is_space(ch) || is_punct(ch)) begin
        e1 = mk_res(ctl_i.is_floating ? TOK_DBL : TOK_INT, start_w, last_w, line_i);
        go_idle = 1'b1;
      end else begin
        e1 = mk_res(TOK_INVALID, start_w, p_w, line_i);
      end
    end

    // Between tokens: count lines, open tokens, emit one-byte tokens and the end token
    if (go_idle) begin
      ctl_o.pending_cr = 1'b0;
      ctl_o.mode       = MODE_IDLE;
      if (is_end) begin
        e2_v = 1'b1;
        e2   = mk_res(TOK_END, p_w, p_w, line_i);
      end else if (!((ch == CH_LF) && ctl_i.pending_cr)) begin
        if (is_space(ch)) begin
          if ((ch == CH_CR) || (ch == CH_LF)) begin
            if (line_i != '1) line_o = line_i + LINE_W'(1);
            ctl_o.pending_cr = (ch == CH_CR);
            if (want_newline_i) begin
              e2_v = 1'b1;
              e2   = mk_res(TOK_PUNCT, p_w, p_w, line_o);
            end
          end
        end else if (is_digit(ch) || (ch == CH_DOT)) begin
          start_pos_o       = pos_i;
          last_pos_o        = pos_i;
          ctl_o.mode        = MODE_MANT;
          ctl_o.seen_dot    = (ch == CH_DOT);
          ctl_o.is_floating = (ch == CH_DOT);
        end else if (ident_begin(ident_extra_i, ch)) begin
          start_pos_o = pos_i;
          last_pos_o  = pos_i;
          ctl_o.mode  = MODE_IDENT;
        end else if ((ch == CH_DQUOTE) || (ch == CH_SQUOTE)) begin
          start_pos_o      = pos_i;
          last_pos_o       = pos_i;
          ctl_o.mode       = MODE_STRING;
          ctl_o.quote_byte = ch;
        end else if ((ch == CH_PLUS) || (ch == CH_MINUS)) begin
          start_pos_o = pos_i;
          last_pos_o  = pos_i;
          ctl_o.mode  = MODE_SIGN;
        end else if (is_punct(ch)) begin
          e2_v = 1'b1;
          e2   = mk_res(TOK_PUNCT, p_w, p_w, line_i);
        end else begin
          e2_v = 1'b1;
          e2   = mk_res(TOK_INVALID, p_w, p_w, line_i);
        end
      end
    end
  end

  // Pack results in order; the final one carries last
  always_comb begin
    res0_o      = e1_v ? e1 : e2;
    res0_o.last = !(e1_v && e2_v);
    res1_o      = e2;
    res1_o.last = 1'b1;
    res_cnt_o   = {1'b0, e1_v} + {1'b0, e2_v};
  end

endmodule

`default_nettype wire

### rtl/core/tts_result_fifo.sv
// Small result queue: takes up to two tokens per cycle, hands out one.
// Depends on tts_pkg for the token record.
`default_nettype none

module tts_result_fifo import tts_pkg::*; (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic [1:0] wr_cnt_i,
  input  res_t            wr0_i,
  input  res_t            wr1_i,
  output logic            room2_o,
  output logic            rd_valid_o,
  output res_t            rd_data_o,
  input  wire logic       rd_en_i
);

  localparam int unsigned AW = $clog2(FIFO_DEPTH);
  localparam int unsigned CW = $clog2(FIFO_DEPTH + 1);

  res_t          mem_q [FIFO_DEPTH];
  logic [AW-1:0] wr_ptr_q, rd_ptr_q, wr_ptr_d, rd_ptr_d, wr_next;
  logic [CW-1:0] cnt_q, cnt_d;
  logic          pop;

  assign pop        = rd_en_i && (cnt_q != '0);
  assign wr_next    = AW'(wr_ptr_q + 1'b1);
  assign wr_ptr_d   = AW'(wr_ptr_q + wr_cnt_i);
  assign rd_ptr_d   = AW'(rd_ptr_q + pop);
  assign cnt_d      = CW'(cnt_q + CW'(wr_cnt_i) - CW'(pop));
  assign room2_o    = (cnt_q <= CW'(FIFO_DEPTH - 2));
  assign rd_valid_o = (cnt_q != '0);
  assign rd_data_o  = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (wr_cnt_i != 2'd0) mem_q[wr_ptr_q] <= wr0_i;
    if (wr_cnt_i == 2'd2) mem_q[wr_next]  <= wr1_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

endmodule

`default_nettype wire

### rtl/core/text_token_scanner_unit.sv
// Text token scanner: one byte per input beat, zero to two token beats out.
// A token beat is offered from the result queue after its byte has passed the input register.
// Throughput: one byte per cycle while the result queue has room for two tokens; a byte
// that yields two tokens gives two output beats, absorbed by a four-entry result queue.
// Reset (rst_ni, async, active low): scanner idle, line 1, position 0,
// all configuration registers zero, queue empty.
`default_nettype none

module text_token_scanner_unit import tts_pkg::*; #(
  parameter int unsigned POSITION_BITS = 32
) (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  // Byte stream in
  input  wire logic                   s_axis_tvalid,
  output logic                        s_axis_tready,
  input  wire logic [7:0]             s_axis_tdata,  // [7:0] data_byte
  input  wire logic                   s_axis_tuser,  // [0] action (1 = end of input)
  // Token stream out
  output logic                        m_axis_tvalid,
  input  wire logic                   m_axis_tready,
  // [2:0] token_type, [34:3] token_start, [66:35] token_end,
  // [98:67] line_number, [103:99] zero
  output logic [OUT_TDATA_W-1:0]      m_axis_tdata,
  output logic                        m_axis_tlast,  // last token of the byte beat
  // Configuration port
  input  wire logic                   psel,
  input  wire logic                   penable,
  input  wire logic                   pwrite,
  input  wire logic [3:0]             paddr,
  input  wire logic [31:0]            pwdata,
  output logic [31:0]                 prdata,
  output logic                        pready
);

  // Positions saturate at the smaller of the parameter width and 32 bits
  localparam int unsigned PosW = (POSITION_BITS < 32) ? POSITION_BITS : 32;

  // ---------------------------------------------------------------------------
  // Configuration registers
  // ---------------------------------------------------------------------------
  logic [31:0] comment_chars_q, ident_extra_q;
  logic        want_newline_q;
  logic        cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      comment_chars_q <= '0;
      ident_extra_q   <= '0;
      want_newline_q  <= 1'b0;
    end else if (cfg_wr) begin
      // Addresses beyond the three registers drop the write
      case (paddr[3:2])
        REG_COMMENT_CHARS: comment_chars_q <= pwdata;
        REG_IDENT_EXTRA:   ident_extra_q   <= pwdata;
        REG_WANT_NEWLINE:  want_newline_q  <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[3:2])
      REG_COMMENT_CHARS: prdata = comment_chars_q;
      REG_IDENT_EXTRA:   prdata = ident_extra_q;
      REG_WANT_NEWLINE:  prdata = {31'd0, want_newline_q};
      default:           prdata = '0;
    endcase
  end

  // ---------------------------------------------------------------------------
  // Input register: hold one byte beat until the queue has room for two tokens
  // ---------------------------------------------------------------------------
  logic       in_valid_q;
  logic       in_action_q;
  logic [7:0] in_byte_q;
  logic       in_take, consume, room2;

  assign consume       = in_valid_q && room2;
  assign s_axis_tready = !in_valid_q || consume;
  assign in_take       = s_axis_tvalid && s_axis_tready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_take) begin
      in_valid_q <= 1'b1;
    end else if (consume) begin
      in_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      in_action_q <= s_axis_tuser;
      in_byte_q   <= s_axis_tdata;
    end
  end

  // ---------------------------------------------------------------------------
  // Scanner state; advances only when a held byte is consumed
  // ---------------------------------------------------------------------------
  scan_ctl_t         ctl_q, ctl_d;
  logic [PosW-1:0]   start_pos_q, start_pos_d;
  logic [PosW-1:0]   last_pos_q, last_pos_d;
  logic [PosW-1:0]   byte_pos_q;
  logic [LINE_W-1:0] line_q, line_d;
  res_t              res0, res1;
  logic [1:0]        res_cnt;

  tts_lexer #(
    .PosW (PosW)
  ) u_lexer (
    .comment_chars_i (comment_chars_q),
    .ident_extra_i   (ident_extra_q),
    .want_newline_i  (want_newline_q),
    .action_i        (in_action_q),
    .byte_i          (in_byte_q),
    .pos_i           (byte_pos_q),
    .ctl_i           (ctl_q),
    .start_pos_i     (start_pos_q),
    .last_pos_i      (last_pos_q),
    .line_i          (line_q),
    .ctl_o           (ctl_d),
    .start_pos_o     (start_pos_d),
    .last_pos_o      (last_pos_d),
    .line_o          (line_d),
    .res0_o          (res0),
    .res1_o          (res1),
    .res_cnt_o       (res_cnt)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctl_q       <= '0;
      start_pos_q <= '0;
      last_pos_q  <= '0;
      byte_pos_q  <= '0;
      line_q      <= LINE_W'(1);
    end else if (consume) begin
      ctl_q       <= ctl_d;
      start_pos_q <= start_pos_d;
      last_pos_q  <= last_pos_d;
      line_q      <= line_d;
      // Every data byte takes a position, zero bytes too; end by action does not
      if (!in_action_q && (byte_pos_q != '1)) begin
        byte_pos_q <= byte_pos_q + PosW'(1);
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Result queue and output packing
  // ---------------------------------------------------------------------------
  res_t head;

  tts_result_fifo u_fifo (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .wr_cnt_i   (consume ? res_cnt : 2'd0),
    .wr0_i      (res0),
    .wr1_i      (res1),
    .room2_o    (room2),
    .rd_valid_o (m_axis_tvalid),
    .rd_data_o  (head),
    .rd_en_i    (m_axis_tready)
  );

  assign m_axis_tdata = {5'd0, head.line, head.tok_stop, head.tok_start, head.tok_type};
  assign m_axis_tlast = head.last;

endmodule

`default_nettype wire

### rtl/core/tts_checker.sv
// Port-level checks on the token output of the text token scanner.
// Depends on tts_pkg; bound into text_token_scanner_unit below.
`default_nettype none

module tts_checker import tts_pkg::*; (
  input wire logic                   clk_i,
  input wire logic                   rst_ni,
  input wire logic                   m_axis_tvalid,
  input wire logic                   m_axis_tready,
  input wire logic [OUT_TDATA_W-1:0] m_axis_tdata,
  input wire logic                   m_axis_tlast
);

  // Hold a stalled token beat
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast))
    else $error("stalled token beat changed");

  // A token never ends before it starts
  a_span_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (m_axis_tdata[34:3] <= m_axis_tdata[66:35]))
    else $error("token end before token start");

  // Line numbers start at one and saturate, never wrap to zero
  a_line_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (m_axis_tdata[98:67] != '0))
    else $error("line number zero");

  // The end token always closes the tokens of its byte beat
  a_end_is_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && (m_axis_tdata[2:0] == TOK_END) |-> m_axis_tlast)
    else $error("end token without tlast");

endmodule

bind text_token_scanner_unit tts_checker u_tts_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tlast  (m_axis_tlast)
);

`default_nettype wire
